>>> rtl/fcr_pkg.sv
`timescale 1ns / 1ps
package fcr_pkg;

  localparam int FIELD_W = 16;

  localparam int CW    = 15;
  localparam int C2W   = 29;
  localparam int NNW   = 32;
  localparam int NK2W  = 64;
  localparam int T0W   = 38;
  localparam int T0MW  = 37;
  localparam int T0LW  = 18;
  localparam int T0HW  = T0MW - T0LW;
  localparam int SUMW  = 76;
  localparam int A2W   = 38;
  localparam int A2LW  = 19;
  localparam int A2HW  = A2W - A2LW;
  localparam int HW    = 39;
  localparam int XW2   = 66;
  localparam int AW    = 33;
  localparam int T1W   = 39;
  localparam int T2W   = 34;
  localparam int DW    = 40;
  localparam int QW    = 25;
  localparam int T3SW  = 67;
  localparam int T4PW  = 63;

  localparam logic [CW-1:0]      C_ONE   = 15'd16384;
  localparam logic [C2W-1:0]     ONE_Q28 = 29'h1000_0000;
  localparam logic [QW-1:0]      ONE_Q24 = 25'h100_0000;
  localparam logic [FIELD_W-1:0] R_ONE   = 16'h8000;

  typedef struct packed {
    logic [CW-1:0]         c;
    logic [C2W-1:0]        c2;
    logic [C2W-1:0]        s2;
    logic signed [T0W-1:0] t0;
  } side1_t;

  typedef struct packed {
    logic [CW-1:0]  c;
    logic [C2W-1:0] c2;
    logic [C2W-1:0] s2;
    logic [A2W-1:0] a2b2;
  } side2_t;

  typedef struct packed {
    logic [DW-1:0] num2;
    logic [DW-1:0] den2;
    logic          zero;
  } side3_t;

  typedef struct packed {
    logic [QW-1:0] rs;
    logic          zero;
  } side4_t;

endpackage

>>> rtl/fcr_in_if.sv
`timescale 1ns / 1ps
interface fcr_in_if;
  import fcr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] cos_incidence;
  logic [FIELD_W-1:0]        real_index;
  logic [FIELD_W-1:0]        extinction;

  modport source (output valid, cos_incidence, real_index, extinction, input ready);
  modport sink   (input valid, cos_incidence, real_index, extinction, output ready);

endinterface

>>> rtl/fcr_out_if.sv
`timescale 1ns / 1ps
interface fcr_out_if;
  import fcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] reflectance;

  modport source (output valid, reflectance, input ready);
  modport sink   (input valid, reflectance, output ready);

endinterface

>>> rtl/fcr_sqrt.sv
`timescale 1ns / 1ps
module fcr_sqrt #(
  parameter int X_W    = 76,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [X_W-1:0]    in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [X_W/2-1:0]  out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int N  = X_W / 2;
  localparam int RW = N + 1;
  localparam int TW = N + 3;

  logic              v_r    [N];
  logic              rdy    [N+1];
  logic [X_W-1:0]    xs_r   [N];
  logic [RW-1:0]     rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [SIDE_W-1:0] side_r [N];

  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic              v_in;
    logic [X_W-1:0]    xs_in;
    logic [RW-1:0]     rem_in;
    logic [N-1:0]      root_in;
    logic [SIDE_W-1:0] side_in;
    logic [TW-1:0]     remw;
    logic [TW-1:0]     trial;
    logic [TW-1:0]     diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign xs_in   = in_x;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign xs_in   = xs_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];
    assign remw   = {rem_in, xs_in[X_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = remw >= trial;
    assign diff   = remw - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in) begin
        xs_r[k]   <= xs_in << 2;
        rem_r[k]  <= ge ? diff[RW-1:0] : remw[RW-1:0];
        root_r[k] <= {root_in[N-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

>>> rtl/fcr_div.sv
`timescale 1ns / 1ps
module fcr_div #(
  parameter int D_W    = 40,
  parameter int Q_W    = 25,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [D_W-1:0]    in_num,
  input  logic [D_W-1:0]    in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  // numerator never exceeds denominator: first step yields the integer bit

  logic              v_r    [Q_W];
  logic              rdy    [Q_W+1];
  logic [D_W-1:0]    rem_r  [Q_W];
  logic [D_W-1:0]    den_r  [Q_W];
  logic [Q_W-1:0]    quot_r [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  assign rdy[Q_W] = out_ready;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              v_in;
    logic [D_W:0]      r2;
    logic [D_W-1:0]    den_in;
    logic [Q_W-1:0]    quot_in;
    logic [SIDE_W-1:0] side_in;
    logic [D_W:0]      dext;
    logic [D_W:0]      diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign r2      = {1'b0, in_num};
      assign den_in  = in_den;
      assign quot_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign r2      = {rem_r[k-1], 1'b0};
      assign den_in  = den_r[k-1];
      assign quot_in = quot_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];
    assign dext   = {1'b0, den_in};
    assign ge     = r2 >= dext;
    assign diff   = r2 - dext;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in) begin
        rem_r[k]  <= ge ? diff[D_W-1:0] : r2[D_W-1:0];
        den_r[k]  <= den_in;
        quot_r[k] <= {quot_in[Q_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[Q_W-1];
  assign out_quot  = quot_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

>>> rtl/fresnel_conductor_reflectance.sv
`timescale 1ns / 1ps
// Pipeline from input transfer to result: 5 front stages, 38-stage and
// 33-stage root pipelines, 1 + 3 middle stages, two 25-stage dividers, 2 end stages.
// Throughput: one item per cycle while the output is not stalled; every stage has its own valid bit and takes a new
// item whenever it is empty or its successor moves on.
// Reset: synchronous, active low; clears the valid bits only.
module fresnel_conductor_reflectance (
  input  logic      clk,
  input  logic      rst_n,
  fcr_in_if.sink    in_ch,
  fcr_out_if.source out_ch
);
  import fcr_pkg::*;

  localparam int S1W = $bits(side1_t);
  localparam int S2W = $bits(side2_t);
  localparam int S3W = $bits(side3_t);
  localparam int S4W = $bits(side4_t);

  // ---- F1: clamp
  logic               f1_v_r, f1_rdy, f2_rdy;
  logic [CW-1:0]      f1_c_r;
  logic [FIELD_W-1:0] f1_n_r, f1_k_r;
  logic [CW-1:0]      c_clamp;

  always_comb begin
    if (in_ch.cos_incidence[FIELD_W-1]) begin
      c_clamp = '0;
    end else if (in_ch.cos_incidence[CW-1:0] > C_ONE) begin
      c_clamp = C_ONE;
    end else begin
      c_clamp = in_ch.cos_incidence[CW-1:0];
    end
  end

  assign f1_rdy      = !f1_v_r || f2_rdy;
  assign in_ch.ready = f1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_rdy) begin
      f1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy && in_ch.valid) begin
      f1_c_r <= c_clamp;
      f1_n_r <= in_ch.real_index;
      f1_k_r <= in_ch.extinction;
    end
  end

  // ---- F2: squares
  logic            f2_v_r, f3_rdy;
  logic [CW-1:0]   f2_c_r;
  logic [C2W-1:0]  f2_c2_r;
  logic [NNW-1:0]  f2_nn_r, f2_kk_r, f2_nk_r;
  logic [2*CW-1:0] c_sq;
  logic [NNW-1:0]  nn, kk, nk;

  assign c_sq   = f1_c_r * f1_c_r;
  assign nn     = f1_n_r * f1_n_r;
  assign kk     = f1_k_r * f1_k_r;
  assign nk     = f1_n_r * f1_k_r;
  assign f2_rdy = !f2_v_r || f3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (f2_rdy) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_rdy && f1_v_r) begin
      f2_c_r  <= f1_c_r;
      f2_c2_r <= c_sq[C2W-1:0];
      f2_nn_r <= nn;
      f2_kk_r <= kk;
      f2_nk_r <= nk;
    end
  end

  // ---- F3: t0 and n^2 k^2
  logic                  f3_v_r, f4_rdy;
  side1_t                f3_sd_r;
  logic [T0MW-1:0]       f3_mag_r;
  logic [NK2W-1:0]       f3_nk2_r;
  logic [C2W-1:0]        s2;
  logic signed [T0W-1:0] t0, t0_neg;
  logic [NK2W-1:0]       nk2;

  assign s2     = ONE_Q28 - f2_c2_r;
  assign t0     = $signed({2'b00, f2_nn_r, 4'b0000}) - $signed({2'b00, f2_kk_r, 4'b0000})
                - $signed({9'd0, s2});
  assign t0_neg = -t0;
  assign nk2    = f2_nk_r * f2_nk_r;
  assign f3_rdy = !f3_v_r || f4_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_v_r <= 1'b0;
    end else if (f3_rdy) begin
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f3_rdy && f2_v_r) begin
      f3_sd_r.c  <= f2_c_r;
      f3_sd_r.c2 <= f2_c2_r;
      f3_sd_r.s2 <= s2;
      f3_sd_r.t0 <= t0;
      f3_mag_r   <= t0[T0W-1] ? t0_neg[T0MW-1:0] : t0[T0MW-1:0];
      f3_nk2_r   <= nk2;
    end
  end

  // ---- F4: t0^2 partial products
  logic                 f4_v_r, f5_rdy;
  side1_t               f4_sd_r;
  logic [NK2W-1:0]      f4_nk2_r;
  logic [2*T0HW-1:0]    f4_hh_r;
  logic [T0HW+T0LW-1:0] f4_hl_r;
  logic [2*T0LW-1:0]    f4_ll_r;
  logic [T0HW-1:0]      mag_hi;
  logic [T0LW-1:0]      mag_lo;
  logic [2*T0HW-1:0]    hh;
  logic [T0HW+T0LW-1:0] hl;
  logic [2*T0LW-1:0]    ll;

  assign mag_hi = f3_mag_r[T0MW-1:T0LW];
  assign mag_lo = f3_mag_r[T0LW-1:0];
  assign hh     = mag_hi * mag_hi;
  assign hl     = mag_hi * mag_lo;
  assign ll     = mag_lo * mag_lo;
  assign f4_rdy = !f4_v_r || f5_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f4_v_r <= 1'b0;
    end else if (f4_rdy) begin
      f4_v_r <= f3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f4_rdy && f3_v_r) begin
      f4_sd_r  <= f3_sd_r;
      f4_nk2_r <= f3_nk2_r;
      f4_hh_r  <= hh;
      f4_hl_r  <= hl;
      f4_ll_r  <= ll;
    end
  end

  // ---- F5: radicand of a^2+b^2
  logic            f5_v_r, sq1_in_ready;
  side1_t          f5_sd_r;
  logic [SUMW-1:0] f5_sum_r;
  logic [SUMW-1:0] sum;

  assign sum = (SUMW'(f4_hh_r) << (2 * T0LW)) + (SUMW'(f4_hl_r) << (T0LW + 1))
             + SUMW'(f4_ll_r) + (SUMW'(f4_nk2_r) << 10);
  assign f5_rdy = !f5_v_r || sq1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f5_v_r <= 1'b0;
    end else if (f5_rdy) begin
      f5_v_r <= f4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f5_rdy && f4_v_r) begin
      f5_sd_r  <= f4_sd_r;
      f5_sum_r <= sum;
    end
  end

  // ---- a2b2 root
  logic           sq1_v, m1_rdy;
  logic [A2W-1:0] sq1_root;
  side1_t         sq1_sd;

  fcr_sqrt #(.X_W(SUMW), .SIDE_W(S1W)) u_sqrt_ab (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f5_v_r),
    .in_ready  (sq1_in_ready),
    .in_x      (f5_sum_r),
    .in_side   (f5_sd_r),
    .out_valid (sq1_v),
    .out_ready (m1_rdy),
    .out_root  (sq1_root),
    .out_side  (sq1_sd)
  );

  // ---- M1: (a2b2 + t0) / 2 as Q.56
  logic             m1_v_r, sq2_in_ready;
  side2_t           m1_sd_r;
  logic [XW2-1:0]   m1_x_r;
  logic signed [HW:0] hs;

  assign hs     = $signed({2'b00, sq1_root}) + $signed({{2{sq1_sd.t0[T0W-1]}}, sq1_sd.t0});
  assign m1_rdy = !m1_v_r || sq2_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (m1_rdy) begin
      m1_v_r <= sq1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_rdy && sq1_v) begin
      m1_sd_r.c    <= sq1_sd.c;
      m1_sd_r.c2   <= sq1_sd.c2;
      m1_sd_r.s2   <= sq1_sd.s2;
      m1_sd_r.a2b2 <= sq1_root;
      m1_x_r       <= hs[HW] ? '0 : {hs[HW-1:0], 27'd0};
    end
  end

  // ---- a root
  logic          sq2_v, p1_rdy;
  logic [AW-1:0] sq2_root;
  side2_t        sq2_sd;

  fcr_sqrt #(.X_W(XW2), .SIDE_W(S2W)) u_sqrt_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m1_v_r),
    .in_ready  (sq2_in_ready),
    .in_x      (m1_x_r),
    .in_side   (m1_sd_r),
    .out_valid (sq2_v),
    .out_ready (p1_rdy),
    .out_root  (sq2_root),
    .out_side  (sq2_sd)
  );

  // ---- P1: t1, t2 and product terms of t3
  logic                p1_v_r, p2_rdy;
  logic [T1W-1:0]      p1_t1_r;
  logic [T2W-1:0]      p1_t2_r;
  logic [C2W+A2HW-1:0] p1_pa_r;
  logic [C2W+A2LW-1:0] p1_pb_r;
  logic [2*C2W-1:0]    p1_ss_r;
  logic [C2W-1:0]      p1_s2_r;
  logic [AW+CW-1:0]    ac;
  logic [C2W+A2HW-1:0] pa;
  logic [C2W+A2LW-1:0] pb;
  logic [2*C2W-1:0]    ss;

  assign ac     = sq2_root * sq2_sd.c;
  assign pa     = sq2_sd.c2 * sq2_sd.a2b2[A2W-1:A2LW];
  assign pb     = sq2_sd.c2 * sq2_sd.a2b2[A2LW-1:0];
  assign ss     = sq2_sd.s2 * sq2_sd.s2;
  assign p1_rdy = !p1_v_r || p2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_r <= sq2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy && sq2_v) begin
      p1_t1_r <= {1'b0, sq2_sd.a2b2} + T1W'(sq2_sd.c2);
      p1_t2_r <= ac[T2W+12:13];
      p1_pa_r <= pa;
      p1_pb_r <= pb;
      p1_ss_r <= ss;
      p1_s2_r <= sq2_sd.s2;
    end
  end

  // ---- P2: rs operands, t3 sum, t2 s2
  logic            p2_v_r, p3_rdy;
  logic [DW-1:0]   p2_num1_r, p2_den1_r;
  logic [T3SW-1:0] p2_t3s_r;
  logic [T4PW-1:0] p2_t4p_r;
  logic [T1W-1:0]  t2e;
  logic [T4PW-1:0] t4p;

  assign t2e    = T1W'(p1_t2_r);
  assign t4p    = p1_t2_r * p1_s2_r;
  assign p2_rdy = !p2_v_r || p3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_rdy && p1_v_r) begin
      p2_den1_r <= DW'(p1_t1_r) + DW'(p1_t2_r);
      p2_num1_r <= (p1_t1_r > t2e) ? DW'(p1_t1_r - t2e) : '0;
      p2_t3s_r  <= (T3SW'(p1_pa_r) << A2LW) + T3SW'(p1_pb_r) + T3SW'(p1_ss_r);
      p2_t4p_r  <= t4p;
    end
  end

  // ---- P3: rp operands
  logic          p3_v_r, dv1_in_ready;
  logic [DW-1:0] p3_num1_r, p3_den1_r;
  side3_t        p3_sd_r;
  logic [DW-1:0] t3, t4, den2;

  assign t3     = DW'(p2_t3s_r[T3SW-1:28]);
  assign t4     = DW'(p2_t4p_r[T4PW-1:28]);
  assign den2   = t3 + t4;
  assign p3_rdy = !p3_v_r || dv1_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (p3_rdy) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_rdy && p2_v_r) begin
      p3_num1_r    <= p2_num1_r;
      p3_den1_r    <= p2_den1_r;
      p3_sd_r.num2 <= (t3 > t4) ? t3 - t4 : '0;
      p3_sd_r.den2 <= den2;
      p3_sd_r.zero <= (p2_den1_r == '0) || (den2 == '0);
    end
  end

  // ---- rs and q dividers
  logic          dv1_v, dv2_in_ready, dv2_v, z1_rdy;
  logic [QW-1:0] dv1_quot, dv2_quot;
  side3_t        dv1_sd;
  side4_t        dv2_in_sd, dv2_sd;

  fcr_div #(.D_W(DW), .Q_W(QW), .SIDE_W(S3W)) u_div_rs (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p3_v_r),
    .in_ready  (dv1_in_ready),
    .in_num    (p3_num1_r),
    .in_den    (p3_den1_r),
    .in_side   (p3_sd_r),
    .out_valid (dv1_v),
    .out_ready (dv2_in_ready),
    .out_quot  (dv1_quot),
    .out_side  (dv1_sd)
  );

  assign dv2_in_sd.rs   = dv1_quot;
  assign dv2_in_sd.zero = dv1_sd.zero;

  fcr_div #(.D_W(DW), .Q_W(QW), .SIDE_W(S4W)) u_div_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv1_v),
    .in_ready  (dv2_in_ready),
    .in_num    (dv1_sd.num2),
    .in_den    (dv1_sd.den2),
    .in_side   (dv2_in_sd),
    .out_valid (dv2_v),
    .out_ready (z1_rdy),
    .out_quot  (dv2_quot),
    .out_side  (dv2_sd)
  );

  // ---- Z1: rp = rs q
  logic            z1_v_r, z1_zero_r, z2_rdy;
  logic [QW-1:0]   z1_rs_r, z1_rp_r;
  logic [QW-1:0]   rsc, qc;
  logic [2*QW-1:0] rq;

  assign rsc    = (dv2_sd.rs > ONE_Q24) ? ONE_Q24 : dv2_sd.rs;
  assign qc     = (dv2_quot > ONE_Q24) ? ONE_Q24 : dv2_quot;
  assign rq     = rsc * qc;
  assign z1_rdy = !z1_v_r || z2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_v_r <= 1'b0;
    end else if (z1_rdy) begin
      z1_v_r <= dv2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (z1_rdy && dv2_v) begin
      z1_rs_r   <= rsc;
      z1_rp_r   <= rq[2*QW-2:QW-1];
      z1_zero_r <= dv2_sd.zero;
    end
  end

  // ---- Z2: output register
  logic               z2_v_r;
  logic [FIELD_W-1:0] z2_res_r;
  logic [QW:0]        rr_sum;
  logic [FIELD_W-1:0] res;

  assign rr_sum = {1'b0, z1_rs_r} + {1'b0, z1_rp_r};
  assign res    = rr_sum[QW:QW-FIELD_W+1];
  assign z2_rdy = !z2_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z2_v_r <= 1'b0;
    end else if (z2_rdy) begin
      z2_v_r <= z1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (z2_rdy && z1_v_r) begin
      z2_res_r <= (z1_zero_r || res > R_ONE) ? R_ONE : res;
    end
  end

  assign out_ch.valid       = z2_v_r;
  assign out_ch.reflectance = z2_res_r;

`ifndef SYNTHESIS
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_ch.valid || out_ch.ready) |-> in_ch.ready)
    else $error("input stalled with a free output stage");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.reflectance <= R_ONE))
    else $error("reflectance above one");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (z1_v_r && z1_zero_r && z2_rdy) |=> (out_ch.valid && out_ch.reflectance == R_ONE))
    else $error("zero denominator did not give one");
`endif

endmodule

>>> tb/sv/tb_fresnel_conductor_reflectance.sv
`timescale 1ns / 1ps
module tb_fresnel_conductor_reflectance;
  import fcr_pkg::*;

  typedef struct {
    logic signed [15:0] cos_incidence;
    logic [15:0]        real_index;
    logic [15:0]        extinction;
  } fresnel_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fcr_in_if  in_ch();
  fcr_out_if out_ch();

  fresnel_conductor_reflectance u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fresnel_item_t     pending_q[$];
  logic [15:0]       reflect_q[$];
  int unsigned       fail_cnt = 0;
  bit                drain_req = 1'b0;
  int unsigned       hold_req = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // floor(sqrt(x)), x below 2^80
  function automatic logic [39:0] isqrt(input logic [79:0] x);
    logic [39:0]  r;
    logic [39:0]  cand;
    logic [79:0]  sq;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      cand = r | (40'd1 << b);
      sq = 80'(cand) * 80'(cand);
      if (sq <= x) r = cand;
    end
    return r;
  endfunction

  function automatic logic [15:0] fresnel_reflectance(input fresnel_item_t it);
    logic [63:0]          c, c2, s2, n2, k2, t0mag, a2b2, h, a, t1, t2, t3, t4;
    logic [63:0]          num, den, rs, q, rp, res;
    logic signed [65:0]   t0, hs;
    logic [79:0]          sum, x;
    logic [127:0]         wide;
    if (it.cos_incidence[15]) c = 64'd0;
    else c = (it.cos_incidence > 16384) ? 64'd16384 : 64'(it.cos_incidence[14:0]);
    c2 = c * c;
    s2 = (64'd1 << 28) - c2;
    n2 = (64'(it.real_index) * 64'(it.real_index)) << 4;
    k2 = (64'(it.extinction) * 64'(it.extinction)) << 4;
    t0 = $signed({2'b0, n2}) - $signed({2'b0, k2}) - $signed({2'b0, s2});
    t0mag = t0 < 0 ? 64'(-t0) : 64'(t0);
    sum = 80'(t0mag) * 80'(t0mag) + 80'(n2 << 2) * 80'(k2);
    a2b2 = 64'(isqrt(sum));
    hs = $signed({2'b0, a2b2}) + t0;
    h = hs < 0 ? 64'd0 : 64'(hs);
    x = 80'(h) << 27;
    a = 64'(isqrt(x));
    t2 = (a * c) >> 13;
    t1 = a2b2 + c2;
    den = t1 + t2;
    if (den == 0) return R_ONE;
    num = t1 > t2 ? t1 - t2 : 64'd0;
    rs = (num << 24) / den;
    wide = 128'(c2) * 128'(a2b2) + 128'(s2) * 128'(s2);
    t3 = 64'(wide >> 28);
    t4 = (t2 * s2) >> 28;
    den = t3 + t4;
    if (den == 0) return R_ONE;
    num = t3 > t4 ? t3 - t4 : 64'd0;
    q = (num << 24) / den;
    if (q > (64'd1 << 24)) q = 64'd1 << 24;
    if (rs > (64'd1 << 24)) rs = 64'd1 << 24;
    rp = (rs * q) >> 24;
    res = (rs + rp) >> 10;
    if (res > 64'd32768) res = 64'd32768;
    return res[15:0];
  endfunction

  task automatic push_item(input logic [15:0] ci, input logic [15:0] n, input logic [15:0] k);
    fresnel_item_t it;
    it.cos_incidence = ci;
    it.real_index = n;
    it.extinction = k;
    pending_q.push_back(it);
  endtask

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cos_incidence <= '0;
      in_ch.real_index <= '0;
      in_ch.extinction <= '0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else begin
      if (in_ch.valid) begin
        reflect_q.push_back(fresnel_reflectance('{in_ch.cos_incidence, in_ch.real_index,
                                                  in_ch.extinction}));
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (drain_req && (reflect_q.size() != 0 || in_ch.valid)) begin
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        fresnel_item_t it;
        it = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cos_incidence <= it.cos_incidence;
        in_ch.real_index <= it.real_index;
        in_ch.extinction <= it.extinction;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  int unsigned hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reflect_q.size() == 0) begin
          $error("unexpected transfer: reflectance %0d", out_ch.reflectance);
          fail_cnt <= fail_cnt + 1;
        end else begin
          logic [15:0] exp_r;
          exp_r = reflect_q.pop_front();
          if (exp_r !== out_ch.reflectance) begin
            $error("reflectance: expected %0d, got %0d", exp_r, out_ch.reflectance);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      if (hold_req != 0 && hold_cnt == 0) begin
        hold_cnt <= hold_req;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt == 1) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b1;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
    end
  end

  initial begin
    logic [15:0] ci, n, k;
    in_ch.valid = 1'b0;
    in_ch.cos_incidence = '0;
    in_ch.real_index = '0;
    in_ch.extinction = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clamps, zero n/k, extremes, normal and grazing incidence
    push_item(16'h8000, 16'h1000, 16'h1000);
    push_item(16'hFFFF, 16'h2000, 16'h3000);
    push_item(16'h7FFF, 16'h1800, 16'h4000);
    push_item(16'd16385, 16'h1000, 16'h0000);
    push_item(16'd16384, 16'h0000, 16'h0000);
    push_item(16'd0, 16'h0000, 16'h0000);
    push_item(16'd16384, 16'hFFFF, 16'hFFFF);
    push_item(16'd0, 16'hFFFF, 16'hFFFF);
    push_item(16'd16384, 16'hFFFF, 16'h0000);
    push_item(16'd16384, 16'h0000, 16'hFFFF);
    push_item(16'd0, 16'h1000, 16'h0000);
    push_item(16'd16384, 16'h1000, 16'h0000);
    push_item(16'd1, 16'h0001, 16'h0001);
    push_item(16'd8192, 16'h0266, 16'h3400);
    push_item(16'd11585, 16'h2C00, 16'h3000);
    push_item(16'd16383, 16'h1800, 16'h0000);
    push_item(16'h5555, 16'hAAAA, 16'h5555);
    push_item(16'hAAAA, 16'h5555, 16'hAAAA);

    for (int i = 0; i < 1700; i++) begin
      case ($urandom_range(0, 3))
        0: ci = 16'($urandom);
        1: ci = 16'($urandom_range(0, 16384));
        2: ci = 16'($urandom_range(0, 1) ? $urandom_range(16370, 16384)
                                         : $urandom_range(0, 16));
        default: ci = 16'($urandom_range(0, 16384));
      endcase
      n = 16'($urandom_range(0, 1) ? $urandom_range(0, 16'h6000) : $urandom);
      k = 16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 16'h5000));
      if ($urandom_range(0, 30) == 0) k = '0;
      push_item(ci, n, k);
      if (i == 400) begin
        wait (pending_q.size() == 0);
        hold_req = 400;
        wait (hold_cnt != 0);
        hold_req = 0;
      end
      if (i == 900) begin
        wait (pending_q.size() == 0);
        drain_req = 1'b1;
        wait (reflect_q.size() == 0 && !in_ch.valid);
        repeat (20) @(posedge clk);
        drain_req = 1'b0;
      end
    end
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    wait (reflect_q.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && reflect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
